@@ hw/rtl/sd_spi_command_engine_macros.svh @@
// assertion helpers shared by the command engine modules
`ifndef SD_SPI_COMMAND_ENGINE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SDCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define SDCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SDCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hw/rtl/sdce_pkg.sv @@
`default_nettype none

package sdce_pkg;

    // command tracking phase of the front
    typedef enum logic [0:0] {
        PH_IDLE,
        PH_POLL
    } t_phase;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        JOB_FRAME,
        JOB_POLL,
        JOB_FINISH
    } t_job_kind;

    // one queued job
    typedef struct packed {
        t_job_kind   kind;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [7:0]  resp;
        logic        timed_out;
    } t_job;

    // byte position inside a command frame
    typedef enum logic [3:0] {
        BT_DESEL,
        BT_SEL,
        BT_CMD,
        BT_ARG3,
        BT_ARG2,
        BT_ARG1,
        BT_ARG0,
        BT_CRC,
        BT_EXTRA,
        BT_POLL
    } t_beat;

    // one result item
    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       chip_select_low;
        logic       want_reply;
        logic       done_res;
        logic [7:0] response;
        logic       timed_out;
        logic       last;
    } t_result;

    // command indexes with special handling
    localparam logic [5:0] IDX_GO_IDLE      = 6'd0;
    localparam logic [5:0] IDX_SEND_IF_COND = 6'd8;
    localparam logic [5:0] IDX_STOP_TRAN    = 6'd12;
    localparam logic [5:0] IDX_APP_CMD      = 6'd55;

    // frame bytes
    localparam logic [7:0] BYTE_DUMMY  = 8'hFF;
    localparam logic [7:0] CMD_START   = 8'h40;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_DEFAULT = 8'h01;

    // reply busy flag and poll limit after reset
    localparam int         REPLY_BUSY_BIT   = 7;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd10;

endpackage

`default_nettype wire

@@ hw/rtl/sdce_front.sv @@
`default_nettype none
`include "sd_spi_command_engine_macros.svh"

module sdce_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [7:0]        i_cfg_wr_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_func,
    input  wire logic [5:0]        i_cmd_index,
    input  wire logic              i_app_cmd,
    input  wire logic [31:0]       i_argument,
    input  wire logic [7:0]        i_miso_byte,
    input  wire logic              i_full,
    output logic                   o_push,
    output sdce_pkg::t_job         o_job
);

    sdce_pkg::t_phase r_phase, n_phase;
    logic [5:0]       r_pend_idx, n_pend_idx;
    logic [31:0]      r_pend_arg, n_pend_arg;
    logic             r_app_active, n_app_active;
    logic [7:0]       r_polls_left, n_polls_left;
    logic [7:0]       r_poll_limit;

    logic       w_accept;
    logic [7:0] w_limit;
    logic [7:0] w_polls_dec;
    logic       w_reply_ready;
    logic       w_prefix_ok;

    // handshake and shared terms
    assign o_ready       = !i_full;
    assign w_accept      = i_valid && o_ready;
    assign w_limit       = (r_poll_limit == 8'd0) ? 8'd1 : r_poll_limit;
    assign w_polls_dec   = r_polls_left - 8'd1;
    assign w_reply_ready = !i_miso_byte[sdce_pkg::REPLY_BUSY_BIT];
    assign w_prefix_ok   = (i_miso_byte[7:1] == 7'd0);

    // poll limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= sdce_pkg::POLL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    // next command state
    always_comb begin
        n_phase      = r_phase;
        n_pend_idx   = r_pend_idx;
        n_pend_arg   = r_pend_arg;
        n_app_active = r_app_active;
        n_polls_left = r_polls_left;
        if (w_accept) begin
            if (!i_func) begin
                n_pend_idx   = i_cmd_index;
                n_pend_arg   = i_argument;
                n_app_active = i_app_cmd;
                n_polls_left = w_limit;
                n_phase      = sdce_pkg::PH_POLL;
            end else begin
                case (r_phase)
                    sdce_pkg::PH_POLL: begin
                        if (w_reply_ready) begin
                            if (r_app_active && w_prefix_ok) begin
                                // prefix accepted, the real command follows
                                n_app_active = 1'b0;
                                n_polls_left = w_limit;
                            end else begin
                                n_phase      = sdce_pkg::PH_IDLE;
                                n_app_active = 1'b0;
                                n_polls_left = 8'd0;
                            end
                        end else if (w_polls_dec == 8'd0) begin
                            n_phase      = sdce_pkg::PH_IDLE;
                            n_app_active = 1'b0;
                            n_polls_left = 8'd0;
                        end else begin
                            n_polls_left = w_polls_dec;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // job classification
    always_comb begin
        o_push           = 1'b0;
        o_job.kind       = sdce_pkg::JOB_FINISH;
        o_job.idx        = 6'd0;
        o_job.arg        = 32'd0;
        o_job.resp       = i_miso_byte;
        o_job.timed_out  = 1'b0;
        if (w_accept) begin
            if (!i_func) begin
                o_push     = 1'b1;
                o_job.kind = sdce_pkg::JOB_FRAME;
                o_job.idx  = i_app_cmd ? sdce_pkg::IDX_APP_CMD : i_cmd_index;
                o_job.arg  = i_app_cmd ? 32'd0 : i_argument;
            end else begin
                case (r_phase)
                    sdce_pkg::PH_POLL: begin
                        o_push = 1'b1;
                        if (w_reply_ready) begin
                            if (r_app_active && w_prefix_ok) begin
                                o_job.kind = sdce_pkg::JOB_FRAME;
                                o_job.idx  = r_pend_idx;
                                o_job.arg  = r_pend_arg;
                            end
                        end else if (w_polls_dec == 8'd0) begin
                            o_job.timed_out = 1'b1;
                        end else begin
                            o_job.kind = sdce_pkg::JOB_POLL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sdce_pkg::PH_IDLE;
            r_app_active <= 1'b0;
            r_polls_left <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_app_active <= n_app_active;
            r_polls_left <= n_polls_left;
        end
    end

    // pending command payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_idx <= 6'd0;
            r_pend_arg <= 32'd0;
        end else begin
            r_pend_idx <= n_pend_idx;
            r_pend_arg <= n_pend_arg;
        end
    end

    `SDCE_ASSERT(a_idle_no_polls, i_clk, i_rst_n, (r_phase == sdce_pkg::PH_IDLE) |-> (r_polls_left == 8'd0), "idle with polls left")
    `SDCE_ASSERT(a_idle_no_prefix, i_clk, i_rst_n, (r_phase == sdce_pkg::PH_IDLE) |-> !r_app_active, "idle with app prefix active")

endmodule

`default_nettype wire

@@ hw/rtl/sdce_queue.sv @@
`default_nettype none
`include "sd_spi_command_engine_macros.svh"

module sdce_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sdce_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output sdce_pkg::t_job      o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdce_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // pointer and fill tracking
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `SDCE_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `SDCE_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ hw/rtl/sdce_back.sv @@
`default_nettype none
`include "sd_spi_command_engine_macros.svh"

module sdce_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire sdce_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output sdce_pkg::t_result   o_result
);

    sdce_pkg::t_beat   r_beat, n_beat;
    sdce_pkg::t_beat   w_beat;
    sdce_pkg::t_result r_out, w_res;
    logic              r_out_valid;
    logic              w_load;
    logic              w_final;
    logic              w_stop_tran;

    assign w_stop_tran = (i_job.idx == sdce_pkg::IDX_STOP_TRAN);
    assign w_load      = !i_empty && (!r_out_valid || i_ready);
    assign o_pop       = w_load && w_final;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    // stop transmission skips the two dummy bytes
    always_comb begin
        w_beat = r_beat;
        if (r_beat == sdce_pkg::BT_DESEL && w_stop_tran) begin
            w_beat = sdce_pkg::BT_CMD;
        end
    end

    // result for the current beat
    always_comb begin
        w_res.mosi_byte       = sdce_pkg::BYTE_DUMMY;
        w_res.chip_select_low = 1'b1;
        w_res.want_reply      = 1'b0;
        w_res.done_res        = 1'b0;
        w_res.response        = 8'd0;
        w_res.timed_out       = 1'b0;
        w_res.last            = 1'b0;
        w_final               = 1'b0;
        case (i_job.kind)
            sdce_pkg::JOB_FRAME: begin
                case (w_beat)
                    sdce_pkg::BT_DESEL: begin
                        w_res.chip_select_low = 1'b0;
                    end
                    sdce_pkg::BT_CMD: begin
                        w_res.mosi_byte = sdce_pkg::CMD_START | {2'b00, i_job.idx};
                    end
                    sdce_pkg::BT_ARG3: begin
                        w_res.mosi_byte = i_job.arg[31:24];
                    end
                    sdce_pkg::BT_ARG2: begin
                        w_res.mosi_byte = i_job.arg[23:16];
                    end
                    sdce_pkg::BT_ARG1: begin
                        w_res.mosi_byte = i_job.arg[15:8];
                    end
                    sdce_pkg::BT_ARG0: begin
                        w_res.mosi_byte = i_job.arg[7:0];
                    end
                    sdce_pkg::BT_CRC: begin
                        if (i_job.idx == sdce_pkg::IDX_GO_IDLE) begin
                            w_res.mosi_byte = sdce_pkg::CRC_CMD0;
                        end else if (i_job.idx == sdce_pkg::IDX_SEND_IF_COND) begin
                            w_res.mosi_byte = sdce_pkg::CRC_CMD8;
                        end else begin
                            w_res.mosi_byte = sdce_pkg::CRC_DEFAULT;
                        end
                    end
                    sdce_pkg::BT_POLL: begin
                        w_res.want_reply = 1'b1;
                        w_res.last       = 1'b1;
                        w_final          = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            sdce_pkg::JOB_POLL: begin
                w_res.want_reply = 1'b1;
                w_res.last       = 1'b1;
                w_final          = 1'b1;
            end
            default: begin
                w_res.mosi_byte       = 8'd0;
                w_res.chip_select_low = 1'b0;
                w_res.done_res        = 1'b1;
                w_res.response        = i_job.resp;
                w_res.timed_out       = i_job.timed_out;
                w_res.last            = 1'b1;
                w_final               = 1'b1;
            end
        endcase
    end

    // frame sequencer next beat
    always_comb begin
        n_beat = r_beat;
        if (w_load) begin
            if (w_final) begin
                n_beat = sdce_pkg::BT_DESEL;
            end else begin
                case (w_beat)
                    sdce_pkg::BT_DESEL: n_beat = sdce_pkg::BT_SEL;
                    sdce_pkg::BT_SEL:   n_beat = sdce_pkg::BT_CMD;
                    sdce_pkg::BT_CMD:   n_beat = sdce_pkg::BT_ARG3;
                    sdce_pkg::BT_ARG3:  n_beat = sdce_pkg::BT_ARG2;
                    sdce_pkg::BT_ARG2:  n_beat = sdce_pkg::BT_ARG1;
                    sdce_pkg::BT_ARG1:  n_beat = sdce_pkg::BT_ARG0;
                    sdce_pkg::BT_ARG0:  n_beat = sdce_pkg::BT_CRC;
                    sdce_pkg::BT_CRC: begin
                        n_beat = w_stop_tran ? sdce_pkg::BT_EXTRA : sdce_pkg::BT_POLL;
                    end
                    sdce_pkg::BT_EXTRA: n_beat = sdce_pkg::BT_POLL;
                    default:            n_beat = sdce_pkg::BT_DESEL;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= sdce_pkg::BT_DESEL;
            r_out_valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    `SDCE_ASSERT(a_frame_has_job, i_clk, i_rst_n, (r_beat != sdce_pkg::BT_DESEL) |-> !i_empty, "frame in progress without a job")
    `SDCE_ASSERT(a_want_closes, i_clk, i_rst_n, (r_out_valid && r_out.want_reply) |-> (r_out.chip_select_low && r_out.last), "reply byte not selected or not last")
    `SDCE_ASSERT(a_done_closes, i_clk, i_rst_n, (r_out_valid && r_out.done_res) |-> (r_out.last && !r_out.chip_select_low), "done result not last")

endmodule

`default_nettype wire

@@ hw/rtl/sd_spi_command_engine.sv @@
// SD card SPI-mode command engine. A start item (tuser 0) issues one command: CMD55
// first for an application command, the deselect and select dummy bytes (not for
// CMD12), the six-byte frame, one discarded byte for CMD12, then a poll byte that
// asks for the card's reply. Each reply item (tuser 1) returned for a poll byte
// yields the next poll byte, the real command's frame after an accepted CMD55
// reply, or a done item (tuser 1) carrying the R1 byte and a timeout flag; replies
// while no command runs are dropped. The front decodes one input item per cycle,
// while the queue has room, into a job and queues it (QUEUE_DEPTH entries) for
// the back, which emits one output item per cycle while the output is ready: 8 or
// 9 items for a frame job, one for a poll or done job. The poll limit register (reset
// 10, zero acts as one) must be written by the user only while idle; not enforced.
`default_nettype none

module sd_spi_command_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // cmd_index[5:0], app_cmd[6], argument[38:7], miso_byte[46:39], zero[47]
    input  wire logic [47:0] i_s_axis_tdata,
    // func[0]
    input  wire logic        i_s_axis_tuser,
    // result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // mosi_byte[7:0], chip_select_low[8], want_reply[9], response[17:10],
    // timed_out[18], zero[23:19]
    output logic [23:0]      o_m_axis_tdata,
    // done_res[0]
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    sdce_pkg::t_job    w_push_job;
    sdce_pkg::t_job    w_head_job;
    sdce_pkg::t_result w_result;

    // decode and track command state
    sdce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_func        (i_s_axis_tuser),
        .i_cmd_index   (i_s_axis_tdata[5:0]),
        .i_app_cmd     (i_s_axis_tdata[6]),
        .i_argument    (i_s_axis_tdata[38:7]),
        .i_miso_byte   (i_s_axis_tdata[46:39]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    // job queue between front and back
    sdce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    // byte sequencer and output register
    sdce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_head_job),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    // result packing
    assign o_m_axis_tdata = {5'd0, w_result.timed_out, w_result.response,
                             w_result.want_reply, w_result.chip_select_low,
                             w_result.mosi_byte};
    assign o_m_axis_tuser = w_result.done_res;
    assign o_m_axis_tlast = w_result.last;

endmodule

`default_nettype wire
